>>> rtl/osa_ed_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the osa edit distance search core
// no dependencies

package osa_ed_pkg;

    localparam int CHAR_W    = 8;
    localparam int DIST_W    = 10;
    localparam int NUM_W     = 17;
    localparam int LEN_CFG_W = 6;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int DIST_MAX  = 1023;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS_3 = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    // wavefront bundle handed from one cell to the next
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] cur;          // new row value of the sender
        logic [DIST_W-1:0] prev;         // sender's previous row value
        logic [DIST_W-1:0] prev2_own;    // sender's row-before-previous value
        logic [DIST_W-1:0] prev2_prior;  // row-before-previous of the sender's left cell
        logic [CHAR_W-1:0] pchar;        // sender's pattern character
        logic              has_char;     // sender is a pattern cell, not the column head
    } wave_t;

    // broadcast controls common to all cells
    typedef struct packed {
        logic [CHAR_W-1:0] word_char;
        logic [CHAR_W-1:0] prev_char;
        logic              update;
        logic              trans_en;
        logic              clear;
    } cell_ctrl_t;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [DIST_W:0] v);
        return v[DIST_W] ? {DIST_W{1'b1}} : v[DIST_W-1:0];
    endfunction

endpackage

>>> rtl/osa_ed_cell.sv
`timescale 1ns / 1ps
// one pattern column of the distance row: holds two row values, fires on the wavefront
// depends on osa_ed_pkg

module osa_ed_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  osa_ed_pkg::cell_ctrl_t              ctrl,
    input  logic [osa_ed_pkg::CHAR_W-1:0]       pchar,
    input  logic                                active,
    input  logic [osa_ed_pkg::DIST_W-1:0]       init_dist,
    input  osa_ed_pkg::wave_t                   left,
    output osa_ed_pkg::wave_t                   right
);

    localparam int DIST_W = osa_ed_pkg::DIST_W;

    logic [DIST_W-1:0] prev_reg;
    logic [DIST_W-1:0] prev2_reg;
    logic              fresh_reg;
    osa_ed_pkg::wave_t right_reg;
    osa_ed_pkg::wave_t right_next;

    logic [DIST_W-1:0] prev_eff;
    logic [DIST_W-1:0] prev2_eff;
    logic              mismatch;
    logic              trans_hit;
    logic [DIST_W:0]   cand_sub;
    logic [DIST_W:0]   cand_del;
    logic [DIST_W:0]   cand_ins;
    logic [DIST_W:0]   cand_tr;
    logic [DIST_W:0]   best_cand;
    logic [DIST_W-1:0] cur_new;

    // a fresh cell reads as the start-of-word row
    assign prev_eff  = fresh_reg ? init_dist : prev_reg;
    assign prev2_eff = fresh_reg ? '0 : prev2_reg;

    assign mismatch  = (ctrl.word_char != pchar);
    assign trans_hit = ctrl.trans_en && left.has_char &&
                       (ctrl.word_char == left.pchar) && (pchar == ctrl.prev_char);

    assign cand_sub = {1'b0, left.prev} + {{DIST_W{1'b0}}, mismatch};
    assign cand_del = {1'b0, prev_eff} + 1'b1;
    assign cand_ins = {1'b0, left.cur} + 1'b1;
    assign cand_tr  = {1'b0, left.prev2_prior} + 1'b1;

    always_comb
    begin
        best_cand = cand_sub;
        if (cand_del < best_cand)
        begin
            best_cand = cand_del;
        end
        if (cand_ins < best_cand)
        begin
            best_cand = cand_ins;
        end
        if (trans_hit && (cand_tr < best_cand))
        begin
            best_cand = cand_tr;
        end
    end

    always_comb
    begin
        if (!ctrl.update)
        begin
            cur_new = prev_eff;
        end
        else if (active)
        begin
            cur_new = osa_ed_pkg::sat_dist(best_cand);
        end
        else
        begin
            cur_new = osa_ed_pkg::sat_dist(cand_ins);
        end
    end

    always_comb
    begin
        right_next.valid       = left.valid;
        right_next.cur         = cur_new;
        right_next.prev        = prev_eff;
        right_next.prev2_own   = prev2_eff;
        right_next.prev2_prior = left.prev2_own;
        right_next.pchar       = pchar;
        right_next.has_char    = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_reg <= '0;
            fresh_reg <= 1'b1;
        end
        else
        begin
            right_reg <= right_next;
            if (ctrl.clear)
            begin
                fresh_reg <= 1'b1;
            end
            else if (left.valid && ctrl.update)
            begin
                fresh_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (left.valid && ctrl.update)
        begin
            prev2_reg <= prev_eff;
            prev_reg  <= cur_new;
        end
    end

    assign right = right_reg;

endmodule

>>> rtl/osa_edit_distance_nearest_word_core.sv
`timescale 1ns / 1ps
// top level of the nearest-word search by optimal string alignment distance
// depends on osa_ed_pkg and osa_ed_cell

// Streams dictionary words one character per request and measures each word
// against a configured pattern of up to MAX_PATTERN characters, by restricted
// Damerau-Levenshtein (optimal string alignment) distance. The distance row is
// held in a chain of MAX_PATTERN cells, one per pattern column; a request that
// carries a character, or that ends a word, sends a wavefront down the chain,
// one cell per cycle, and keeps the core busy from its acceptance through the
// column head, the MAX_PATTERN cells and a commit step; a word end stays in
// the commit step while an earlier result still waits in the full result
// register. A request with no character that does not end a word takes no
// sweep. Each word end yields one result: the word's distance (saturated at
// 1023), its number since the last restart, and the running smallest
// distance with the number of the first word that reached it; the best starts
// at the pattern length. The result sits in an output register, so the next
// request is taken while it waits. The user must write the pattern registers
// through the configuration port only while the core is idle; the core does
// not enforce this. Writing pattern_length also reloads the best distance.

module osa_edit_distance_nearest_word_core #(
    parameter int MAX_PATTERN  = 32,
    parameter int MAX_WORD_LEN = 1024,
    parameter int MAX_WORDS    = 131072
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [osa_ed_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [osa_ed_pkg::CFG_W-1:0]        cfg_data,
    // character requests
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [osa_ed_pkg::CHAR_W-1:0]       word_char,
    input  logic                                char_present,
    input  logic                                word_last,
    input  logic                                restart_search,
    // word results
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [osa_ed_pkg::DIST_W-1:0]       word_distance,
    output logic [osa_ed_pkg::NUM_W-1:0]        word_number,
    output logic [osa_ed_pkg::DIST_W-1:0]       best_distance,
    output logic [osa_ed_pkg::NUM_W-1:0]        best_word_number
);

    localparam int CHAR_W    = osa_ed_pkg::CHAR_W;
    localparam int DIST_W    = osa_ed_pkg::DIST_W;
    localparam int NUM_W     = osa_ed_pkg::NUM_W;
    localparam int LEN_CFG_W = osa_ed_pkg::LEN_CFG_W;
    localparam int CFG_W     = osa_ed_pkg::CFG_W;
    localparam int DIST_MAX  = osa_ed_pkg::DIST_MAX;
    localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
    localparam int RP_W      = $clog2(MAX_WORD_LEN);
    localparam int RP_MAX    = MAX_WORD_LEN - 1;
    localparam int WN_W      = $clog2(MAX_WORDS);
    localparam int CHARS_PER_WORD = CFG_W / CHAR_W;
    localparam int PAT_CHARS = 4 * CHARS_PER_WORD;

    // configuration registers
    logic [LEN_CFG_W-1:0] pat_len_cfg_reg;
    logic [CFG_W-1:0]     pat_chars_reg [4];

    // request held for the duration of its sweep
    logic [CHAR_W-1:0]    char_reg;
    logic                 present_reg;
    logic                 last_reg;

    osa_ed_pkg::state_t   state_reg;
    osa_ed_pkg::state_t   state_next;
    logic                 src_fire_reg;
    logic                 src_fire_next;

    // word-level state
    logic [RP_W-1:0]      rowpos_reg;
    logic [RP_W-1:0]      rowpos_next;
    logic [CHAR_W-1:0]    prev_char_reg;
    logic [CHAR_W-1:0]    prev_char_next;
    logic [DIST_W-1:0]    prev2_0_reg;
    logic [DIST_W-1:0]    prev2_0_next;
    logic [WN_W-1:0]      word_num_reg;
    logic [WN_W-1:0]      word_num_next;
    logic [DIST_W-1:0]    best_reg;
    logic [DIST_W-1:0]    best_next;
    logic [WN_W-1:0]      best_idx_reg;
    logic [WN_W-1:0]      best_idx_next;
    logic [DIST_W-1:0]    dist_reg;
    logic [DIST_W-1:0]    dist_next;

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [DIST_W-1:0]    out_dist_reg;
    logic [DIST_W-1:0]    out_dist_next;
    logic [NUM_W-1:0]     out_num_reg;
    logic [NUM_W-1:0]     out_num_next;
    logic [DIST_W-1:0]    out_best_reg;
    logic [DIST_W-1:0]    out_best_next;
    logic [NUM_W-1:0]     out_best_num_reg;
    logic [NUM_W-1:0]     out_best_num_next;

    logic                 accept;
    logic                 commit;
    logic [LEN_W-1:0]     len;
    logic [LEN_W-1:0]     cfg_len_lim;
    logic [RP_W:0]        rp_inc;
    logic [DIST_W-1:0]    rp_sat;
    logic [DIST_W-1:0]    rp_inc_sat;
    logic [DIST_W-1:0]    commit_best;
    logic [WN_W-1:0]      commit_best_idx;

    osa_ed_pkg::cell_ctrl_t ctrl;
    osa_ed_pkg::wave_t      wave [MAX_PATTERN + 1];
    logic [MAX_PATTERN:0]   wave_valid;

    // effective pattern length, limited to the chain length
    assign len = (int'(pat_len_cfg_reg) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN)
                                                       : LEN_W'(pat_len_cfg_reg);
    assign cfg_len_lim = (int'(cfg_data[LEN_CFG_W-1:0]) > MAX_PATTERN)
                         ? LEN_W'(MAX_PATTERN) : LEN_W'(cfg_data[LEN_CFG_W-1:0]);

    // column zero of the row is the word position, saturated
    assign rp_inc     = {1'b0, rowpos_reg} + 1'b1;
    assign rp_sat     = (int'(rowpos_reg) > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(rowpos_reg);
    assign rp_inc_sat = (int'(rp_inc) > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(rp_inc);

    // ------------------------------------------------------------------
    // control sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            osa_ed_pkg::ST_IDLE:
            begin
                if (in_valid && (char_present || word_last))
                begin
                    state_next = osa_ed_pkg::ST_SWEEP;
                end
            end
            osa_ed_pkg::ST_SWEEP:
            begin
                // wavefront has left the last cell
                if (wave[MAX_PATTERN].valid)
                begin
                    state_next = osa_ed_pkg::ST_FINISH;
                end
            end
            osa_ed_pkg::ST_FINISH:
            begin
                if (commit)
                begin
                    state_next = osa_ed_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = osa_ed_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            osa_ed_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            osa_ed_pkg::ST_SWEEP:
            begin
                in_ready = 1'b0;
            end
            osa_ed_pkg::ST_FINISH:
            begin
                // a word end waits for room in the result register
                commit = !last_reg || !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept        = in_valid && in_ready;
    assign src_fire_next = accept && (char_present || word_last);

    // ------------------------------------------------------------------
    // cell chain: wave[0] is the column head, wave[j] leaves cell j
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl.word_char = char_reg;
        ctrl.prev_char = prev_char_reg;
        ctrl.update    = present_reg;
        ctrl.trans_en  = (rowpos_reg != '0);
        ctrl.clear     = commit && last_reg;
    end

    always_comb
    begin
        wave[0].valid       = src_fire_reg;
        wave[0].cur         = present_reg ? rp_inc_sat : rp_sat;
        wave[0].prev        = rp_sat;
        wave[0].prev2_own   = prev2_0_reg;
        wave[0].prev2_prior = '0;
        wave[0].pchar       = '0;
        wave[0].has_char    = 1'b0;
    end

    assign wave_valid[0] = wave[0].valid;

    for (genvar g = 1; g <= MAX_PATTERN; g++)
    begin : g_cell
        localparam int K = g - 1;
        logic [CHAR_W-1:0] cell_pchar;
        logic              cell_active;

        // pattern positions past the configured characters read as zero
        if (K < PAT_CHARS)
        begin : g_char
            assign cell_pchar =
                pat_chars_reg[K / CHARS_PER_WORD][(K % CHARS_PER_WORD) * CHAR_W +: CHAR_W];
        end
        else
        begin : g_nochar
            assign cell_pchar = '0;
        end

        assign cell_active = (g <= int'(len));

        osa_ed_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .pchar     (cell_pchar),
            .active    (cell_active),
            .init_dist (DIST_W'(g)),
            .left      (wave[g - 1]),
            .right     (wave[g])
        );

        assign wave_valid[g] = wave[g].valid;
    end

    // tap the row value of the pattern-length column as the wavefront passes
    always_comb
    begin
        dist_next = dist_reg;
        for (int k = 0; k <= MAX_PATTERN; k++)
        begin
            if (wave[k].valid && (k == int'(len)))
            begin
                dist_next = wave[k].cur;
            end
        end
    end

    // ------------------------------------------------------------------
    // word bookkeeping and result
    // ------------------------------------------------------------------
    always_comb
    begin
        if (dist_reg < best_reg)
        begin
            commit_best     = dist_reg;
            commit_best_idx = word_num_reg;
        end
        else
        begin
            commit_best     = best_reg;
            commit_best_idx = best_idx_reg;
        end
    end

    always_comb
    begin
        rowpos_next       = rowpos_reg;
        prev_char_next    = prev_char_reg;
        prev2_0_next      = prev2_0_reg;
        word_num_next     = word_num_reg;
        best_next         = best_reg;
        best_idx_next     = best_idx_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_dist_next     = out_dist_reg;
        out_num_next      = out_num_reg;
        out_best_next     = out_best_reg;
        out_best_num_next = out_best_num_reg;

        // pattern length write reloads the best distance
        if (cfg_write && (cfg_index == osa_ed_pkg::CFG_PATTERN_LENGTH))
        begin
            best_next = DIST_W'(cfg_len_lim);
        end

        // restart applies ahead of the request's own work
        if (accept && restart_search)
        begin
            best_next     = DIST_W'(len);
            best_idx_next = '0;
            word_num_next = '0;
        end

        if (commit && present_reg)
        begin
            if (rowpos_reg != RP_W'(RP_MAX))
            begin
                rowpos_next = rowpos_reg + 1'b1;
            end
            prev_char_next = char_reg;
            prev2_0_next   = rp_sat;
        end

        if (commit && last_reg)
        begin
            best_next         = commit_best;
            best_idx_next     = commit_best_idx;
            out_valid_next    = 1'b1;
            out_dist_next     = dist_reg;
            out_num_next      = NUM_W'(word_num_reg);
            out_best_next     = commit_best;
            out_best_num_next = NUM_W'(commit_best_idx);
            word_num_next     = (word_num_reg == WN_W'(MAX_WORDS - 1)) ? '0
                                                                       : word_num_reg + 1'b1;
            // start a fresh word
            rowpos_next       = '0;
            prev_char_next    = '0;
            prev2_0_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= osa_ed_pkg::ST_IDLE;
            src_fire_reg  <= 1'b0;
            rowpos_reg    <= '0;
            prev_char_reg <= '0;
            prev2_0_reg   <= '0;
            word_num_reg  <= '0;
            best_reg      <= '0;
            best_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_fire_reg  <= src_fire_next;
            rowpos_reg    <= rowpos_next;
            prev_char_reg <= prev_char_next;
            prev2_0_reg   <= prev2_0_next;
            word_num_reg  <= word_num_next;
            best_reg      <= best_next;
            best_idx_reg  <= best_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_cfg_reg  <= '0;
            pat_chars_reg[0] <= '0;
            pat_chars_reg[1] <= '0;
            pat_chars_reg[2] <= '0;
            pat_chars_reg[3] <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                osa_ed_pkg::CFG_PATTERN_LENGTH:  pat_len_cfg_reg  <= cfg_data[LEN_CFG_W-1:0];
                osa_ed_pkg::CFG_PATTERN_CHARS_0: pat_chars_reg[0] <= cfg_data;
                osa_ed_pkg::CFG_PATTERN_CHARS_1: pat_chars_reg[1] <= cfg_data;
                osa_ed_pkg::CFG_PATTERN_CHARS_2: pat_chars_reg[2] <= cfg_data;
                osa_ed_pkg::CFG_PATTERN_CHARS_3: pat_chars_reg[3] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // request payload and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg    <= word_char;
            present_reg <= char_present;
            last_reg    <= word_last;
        end
        dist_reg         <= dist_next;
        out_dist_reg     <= out_dist_next;
        out_num_reg      <= out_num_next;
        out_best_reg     <= out_best_next;
        out_best_num_reg <= out_best_num_next;
    end

    assign out_valid        = out_valid_reg;
    assign word_distance    = out_dist_reg;
    assign word_number      = out_num_reg;
    assign best_distance    = out_best_reg;
    assign best_word_number = out_best_num_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // only one wavefront travels the chain at a time
    a_single_wave: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wave_valid))
        else $error("more than one wavefront in the cell chain");

    // the end of a sweep is only seen while sweeping
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        wave[MAX_PATTERN].valid |-> (state_reg == osa_ed_pkg::ST_SWEEP))
        else $error("wavefront left the chain outside a sweep");

    // the running best never exceeds the distance reported with it
    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (best_distance <= word_distance))
        else $error("best distance above word distance");

    // a new result only comes out of the commit cycle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == osa_ed_pkg::ST_FINISH))
        else $error("result raised outside commit");

endmodule

>>> bench/osa_edit_distance_nearest_word_core_test.sv
`timescale 1ns / 1ps
// self-checking bench for the optimal string alignment nearest-word search core
// depends on osa_ed_pkg and osa_edit_distance_nearest_word_core; scores every request
// in a local row model and compares each word result as it leaves the core

module osa_edit_distance_nearest_word_core_test;

    localparam int CHAR_W    = osa_ed_pkg::CHAR_W;
    localparam int DIST_W    = osa_ed_pkg::DIST_W;
    localparam int NUM_W     = osa_ed_pkg::NUM_W;
    localparam int LEN_CFG_W = osa_ed_pkg::LEN_CFG_W;
    localparam int CFG_W     = osa_ed_pkg::CFG_W;
    localparam int CFG_IDX_W = osa_ed_pkg::CFG_IDX_W;
    localparam int DIST_MAX  = osa_ed_pkg::DIST_MAX;

    localparam int MAX_PATTERN   = 32;
    localparam int MAX_WORD_LEN  = 1024;
    localparam int MAX_WORDS     = 131072;
    // a request with a character walks the whole cell chain before the core is quiet
    localparam int SETTLE_CYCLES = MAX_PATTERN + 8;
    localparam int CYCLE_LIMIT   = 1000000;
    // counted requests per idling phase of the random part
    localparam int PHASE_REQUESTS = 200;
    localparam int RELOAD_EVERY   = 50;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [NUM_W-1:0]  number;
        logic [DIST_W-1:0] best;
        logic [NUM_W-1:0]  best_number;
    } word_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CHAR_W-1:0]    word_char = '0;
    logic                 char_present = 1'b0;
    logic                 word_last = 1'b0;
    logic                 restart_search = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [DIST_W-1:0]    word_distance;
    logic [NUM_W-1:0]     word_number;
    logic [DIST_W-1:0]    best_distance;
    logic [NUM_W-1:0]     best_word_number;

    osa_edit_distance_nearest_word_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .word_char        (word_char),
        .char_present     (char_present),
        .word_last        (word_last),
        .restart_search   (restart_search),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .word_distance    (word_distance),
        .word_number      (word_number),
        .best_distance    (best_distance),
        .best_word_number (best_word_number)
    );

    // -------------------------------------------------------------------
    // local copy of the core state and its pattern registers
    // -------------------------------------------------------------------
    logic [LEN_CFG_W-1:0] pat_len_reg;
    logic [CFG_W-1:0]     pat_chars_reg [0:3];
    int unsigned          row_prev [0:MAX_PATTERN];
    int unsigned          row_prev2 [0:MAX_PATTERN];
    logic [CHAR_W-1:0]    prev_char;
    int unsigned          row_pos;
    int unsigned          word_count;
    int unsigned          best_dist;
    int unsigned          best_num;

    word_result_t expected_words [$];
    word_result_t head_word;
    int           error_count = 0;
    int           requests_sent = 0;
    int           cycle_count = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    // random words draw from a four-letter alphabet when set, so matches are common
    bit           alpha_small = 1'b0;

    // 2 ns period
    initial begin
        forever #1 clk = ~clk;
    end

    // receiver stalls at the rate of the current phase
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // -------------------------------------------------------------------
    // row model helpers
    // -------------------------------------------------------------------
    function automatic int unsigned active_len();
        return (pat_len_reg > MAX_PATTERN) ? MAX_PATTERN : pat_len_reg;
    endfunction

    // pattern positions past the last register read as zero
    function automatic logic [CHAR_W-1:0] pattern_at(input int unsigned k);
        if (k >= 32)
            return '0;
        return pat_chars_reg[k >> 3][(k & 7) * 8 +: 8];
    endfunction

    function automatic int unsigned clamp_dist(input int unsigned v);
        return (v > DIST_MAX) ? DIST_MAX : v;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        if (alpha_small)
            return 8'h61 + $urandom_range(0, 3);
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [255:0] pack_text(input string s);
        logic [255:0] v;
        int           i;
        v = '0;
        for (i = 0; i < s.len() && i < 32; i++)
            v[i * 8 +: 8] = s[i];
        return v;
    endfunction

    // back to the empty-prefix row at the end of each word
    task automatic clear_word();
        int j;
        for (j = 0; j <= MAX_PATTERN; j++) begin
            row_prev[j]  = clamp_dist(j);
            row_prev2[j] = 0;
        end
        prev_char = '0;
        row_pos   = 0;
    endtask

    // advance the distance rows by one accepted request, queue the word result on a word end
    task automatic score_request(input logic [CHAR_W-1:0] ch, input logic present,
                                 input logic last, input logic restart);
        int unsigned  len;
        int unsigned  cand;
        int unsigned  j;
        int unsigned  word_dist;
        int unsigned  next_row [0:MAX_PATTERN];
        logic [CHAR_W-1:0] pc;
        word_result_t res;
        len = active_len();
        // restart acts before the request, a word in progress carries on
        if (restart) begin
            best_dist  = len;
            best_num   = 0;
            word_count = 0;
        end
        if (present) begin
            next_row[0] = clamp_dist(row_pos + 1);
            for (j = 1; j <= len; j++) begin
                pc   = pattern_at(j - 1);
                cand = row_prev[j - 1] + ((ch == pc) ? 0 : 1);
                if (row_prev[j] + 1 < cand)
                    cand = row_prev[j] + 1;
                if (next_row[j - 1] + 1 < cand)
                    cand = next_row[j - 1] + 1;
                // adjacent transposition against the row two characters back
                if (row_pos >= 1 && j >= 2 && ch == pattern_at(j - 2) && pc == prev_char &&
                    row_prev2[j - 2] + 1 < cand)
                    cand = row_prev2[j - 2] + 1;
                next_row[j] = clamp_dist(cand);
            end
            for (j = len + 1; j <= MAX_PATTERN; j++)
                next_row[j] = clamp_dist(next_row[j - 1] + 1);
            row_prev2 = row_prev;
            row_prev  = next_row;
            prev_char = ch;
            if (row_pos < MAX_WORD_LEN - 1)
                row_pos++;
        end
        if (last) begin
            word_dist = clamp_dist(row_prev[len]);
            // only a strictly smaller distance takes over the best
            if (word_dist < best_dist) begin
                best_dist = word_dist;
                best_num  = word_count;
            end
            res.distance    = DIST_W'(word_dist);
            res.number      = NUM_W'(word_count);
            res.best        = DIST_W'(best_dist);
            res.best_number = NUM_W'(best_num);
            expected_words.push_back(res);
            word_count = (word_count + 1) % MAX_WORDS;
            clear_word();
        end
    endtask

    // -------------------------------------------------------------------
    // result checking
    // -------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: result with none expected, distance %0d word %0d",
                         $time, word_distance, word_number);
                error_count++;
            end else begin
                head_word = expected_words.pop_front();
                compare_field("word_distance", head_word.distance, word_distance);
                compare_field("word_number", head_word.number, word_number);
                compare_field("best_distance", head_word.best, best_distance);
                compare_field("best_word_number", head_word.best_number, best_word_number);
            end
        end
    end

    // -------------------------------------------------------------------
    // stimulus primitives
    // -------------------------------------------------------------------

    // one request; valid stays high into the next request when there is no gap
    task automatic send_request(input logic [CHAR_W-1:0] ch, input logic present,
                                input logic last, input logic restart);
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        in_valid       <= 1'b1;
        word_char      <= ch;
        char_present   <= present;
        word_last      <= last;
        restart_search <= restart;
        do
            @(posedge clk);
        while (!in_ready);
        score_request(ch, present, last, restart);
        if (present || last)
            requests_sent++;
    endtask

    // sender holds off until every result is out and the chain has gone quiet
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == osa_ed_pkg::CFG_PATTERN_LENGTH) begin
            pat_len_reg = data[LEN_CFG_W-1:0];
            best_dist   = active_len();
        end else if (idx <= osa_ed_pkg::CFG_PATTERN_CHARS_3) begin
            pat_chars_reg[idx - osa_ed_pkg::CFG_PATTERN_CHARS_0] = data;
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_pattern(input logic [CFG_W-1:0] len_word, input logic [255:0] chars);
        wait_idle();
        write_reg(osa_ed_pkg::CFG_PATTERN_CHARS_0, chars[63:0]);
        write_reg(osa_ed_pkg::CFG_PATTERN_CHARS_1, chars[127:64]);
        write_reg(osa_ed_pkg::CFG_PATTERN_CHARS_2, chars[191:128]);
        write_reg(osa_ed_pkg::CFG_PATTERN_CHARS_3, chars[255:192]);
        write_reg(osa_ed_pkg::CFG_PATTERN_LENGTH, len_word);
    endtask

    // whole word from text, an empty text gives a bare word end
    task automatic send_word(input string s, input logic restart);
        int i;
        if (s.len() == 0)
            send_request('0, 1'b0, 1'b1, restart);
        else
            for (i = 0; i < s.len(); i++)
                send_request(s[i], 1'b1, i == s.len() - 1, restart && i == 0);
    endtask

    // mostly short patterns, now and then an empty, an overlong or a full one
    task automatic load_random_pattern();
        logic [255:0]     chars;
        logic [CFG_W-1:0] len_word;
        int               k;
        int               pick;
        alpha_small = $urandom_range(0, 1);
        for (k = 0; k < 32; k++)
            chars[k * 8 +: 8] = pick_char();
        len_word = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick == 0)
            len_word[LEN_CFG_W-1:0] = 0;
        else if (pick == 1)
            len_word[LEN_CFG_W-1:0] = $urandom_range(MAX_PATTERN, 63);
        else
            len_word[LEN_CFG_W-1:0] = $urandom_range(1, 8);
        load_pattern(len_word, chars);
    endtask

    // a near miss of the pattern most of the time, otherwise random text,
    // with stray empty requests, rare restarts and some bare word-end requests
    task automatic send_random_word();
        logic [CHAR_W-1:0] text [0:47];
        logic [CHAR_W-1:0] tmp;
        logic              restart;
        int                n;
        int                k;
        int                e;
        int                pos;
        if ($urandom_range(0, 9) < 7) begin
            n = active_len();
            for (k = 0; k < n; k++)
                text[k] = pattern_at(k);
            for (e = $urandom_range(0, 2); e > 0; e--) begin
                pos = (n == 0) ? 0 : $urandom_range(0, n - 1);
                case ($urandom_range(0, 3))
                    0: begin
                        if (n > 0)
                            text[pos] = pick_char();
                    end
                    1: begin
                        if (pos < n - 1) begin
                            tmp           = text[pos];
                            text[pos]     = text[pos + 1];
                            text[pos + 1] = tmp;
                        end
                    end
                    2: begin
                        if (n < 47) begin
                            for (k = n; k > pos; k--)
                                text[k] = text[k - 1];
                            text[pos] = pick_char();
                            n++;
                        end
                    end
                    default: begin
                        if (n > 0) begin
                            for (k = pos; k < n - 1; k++)
                                text[k] = text[k + 1];
                            n--;
                        end
                    end
                endcase
            end
        end else begin
            n = $urandom_range(0, 12);
            for (k = 0; k < n; k++)
                text[k] = pick_char();
        end
        restart = ($urandom_range(0, 19) == 0);
        if (n == 0) begin
            send_request(pick_char(), 1'b0, 1'b1, restart);
        end else begin
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_request($urandom_range(0, 255), 1'b0, 1'b0, restart);
                    restart = 1'b0;
                end
                if (k == n - 1 && $urandom_range(0, 7) == 0) begin
                    send_request(text[k], 1'b1, 1'b0, restart);
                    send_request($urandom_range(0, 255), 1'b0, 1'b1, 1'b0);
                end else begin
                    send_request(text[k], 1'b1, k == n - 1, restart);
                end
                restart = 1'b0;
            end
        end
    endtask

    // -------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------

    // reset values: zero-length pattern, best of zero
    task automatic test_reset_defaults();
        send_word("", 1'b0);
        send_word("a", 1'b0);
    endtask

    // exact match, substitution, transposition, deletion, insertion, empty word
    task automatic test_basic_edits();
        tx_idle_pct = 29;
        rx_idle_pct = 65;
        load_pattern(6, pack_text("kitten"));
        send_word("sitting", 1'b1);
        send_word("iktten", 1'b0);
        send_word("kitten", 1'b0);
        send_word("kiten", 1'b0);
        send_word("kittens", 1'b0);
        send_word("", 1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
    endtask

    // pattern and word bytes at both ends of the character range
    task automatic test_byte_extremes();
        load_pattern(4, {224'h0, 32'hFF00_FF00});
        send_request(8'hFF, 1'b1, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b0, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b1, 1'b0);
        send_request(8'h00, 1'b1, 1'b0, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b0, 1'b0);
        send_request(8'hFF, 1'b1, 1'b1, 1'b0);
    endtask

    // restart in the middle of a word, on an empty request, and a word closed
    // by a request that carries no character
    task automatic test_restart_and_empty();
        load_pattern(3, pack_text("kit"));
        send_request("k", 1'b1, 1'b0, 1'b0);
        send_request(8'h5A, 1'b0, 1'b0, 1'b0);
        send_request("i", 1'b1, 1'b0, 1'b1);
        send_request(8'hFF, 1'b0, 1'b0, 1'b1);
        send_request("t", 1'b1, 1'b1, 1'b0);
        send_request("x", 1'b1, 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b1, 1'b0);
    endtask

    // a length above the cell count is cut to it, upper data bits ignored
    task automatic test_overlong_length();
        int k;
        load_pattern(64'hFFFF_FFFF_FFFF_FFE8, {256{1'b1}});
        for (k = 0; k < 32; k++)
            send_request(8'hFF, 1'b1, k == 31, 1'b0);
        send_word("", 1'b0);
        load_pattern(64'h0000_0000_0000_003F, '0);
        send_request(8'h00, 1'b1, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b1, 1'b0);
        load_pattern(MAX_PATTERN, pack_text("abcdefghijklmnopqrstuvwxyz012345"));
        send_word("bacd", 1'b0);
    endtask

    // writes to indexes past the last register leave the pattern alone
    task automatic test_unused_indexes();
        int i;
        load_pattern(4, pack_text("word"));
        for (i = int'(osa_ed_pkg::CFG_PATTERN_CHARS_3) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(i[CFG_IDX_W-1:0], {$urandom, $urandom});
        send_word("wrod", 1'b0);
    endtask

    // new pattern loaded between characters of one word, old rows kept
    task automatic test_mid_word_change();
        load_pattern(4, pack_text("abcd"));
        send_request("a", 1'b1, 1'b0, 1'b0);
        send_request("b", 1'b1, 1'b0, 1'b0);
        load_pattern(5, pack_text("xbcde"));
        send_request("c", 1'b1, 1'b0, 1'b0);
        send_request("d", 1'b1, 1'b1, 1'b0);
    endtask

    // one word long enough for the cells and the row position to saturate
    task automatic test_long_word();
        logic [255:0] chars;
        int           k;
        alpha_small = 1'b0;
        for (k = 0; k < 32; k++)
            chars[k * 8 +: 8] = pick_char();
        load_pattern(MAX_PATTERN, chars);
        for (k = 0; k < MAX_WORD_LEN + 6; k++)
            send_request(pick_char(), 1'b1, k == MAX_WORD_LEN + 5, 1'b0);
    endtask

    // random words under one idling mix, pattern reloaded every few dozen requests
    task automatic test_random_phase(input int tx_pct, input int rx_pct);
        int start;
        int last_reload;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        start       = requests_sent;
        last_reload = requests_sent;
        load_random_pattern();
        while (requests_sent - start < PHASE_REQUESTS) begin
            if (requests_sent - last_reload >= RELOAD_EVERY) begin
                load_random_pattern();
                last_reload = requests_sent;
            end
            send_random_word();
        end
    endtask

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        pat_len_reg = '0;
        pat_chars_reg[0] = '0;
        pat_chars_reg[1] = '0;
        pat_chars_reg[2] = '0;
        pat_chars_reg[3] = '0;
        clear_word();
        word_count = 0;
        best_dist  = 0;
        best_num   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_basic_edits();
        test_byte_extremes();
        test_restart_and_empty();
        test_overlong_length();
        test_unused_indexes();
        test_mid_word_change();
        test_long_word();
        test_random_phase(29, 65);
        test_random_phase(65, 29);
        test_random_phase(0, 0);

        // drain, then let the chain settle in case something stray comes out
        wait_idle();
        if (error_count == 0 && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
